// ----- sv/fpa_pkg.sv -----
package fpa_pkg;

	localparam int MAX_WIDTH_DEF  = 32;
	localparam int GUARD_BITS_DEF = 15;
	localparam int DATA_W         = 32;
	localparam int CFG_W          = 6;
	localparam int CFG_IDX_W      = 2;
	localparam int INT_W          = 6;
	localparam int FRAC_W         = 5;
	localparam int FRAC_MAX       = 31;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RM_ZERO    = 2'd0,
		RM_NEAREST = 2'd1,
		RM_POS     = 2'd2,
		RM_NEG     = 2'd3
	} rmode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INT_BITS   = 2'd0,
		CFG_FRAC_BITS  = 2'd1,
		CFG_ROUND_MODE = 2'd2,
		CFG_SPARE      = 2'd3
	} cfg_idx_t;

	localparam logic [INT_W-1:0]  INT_BITS_RST  = 6'd16;
	localparam logic [FRAC_W-1:0] FRAC_BITS_RST = 5'd16;
	localparam rmode_t            RMODE_RST     = RM_NEAREST;

endpackage

// ----- sv/fpa_if.sv -----
interface fpa_cmd_if import fpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [DATA_W-1:0] operand_a;
	logic [DATA_W-1:0] operand_b;

	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result_value;
	logic              div_by_zero;

	modport source (output valid, result_value, div_by_zero, input ready);
	modport sink   (input valid, result_value, div_by_zero, output ready);
endinterface

// ----- sv/fixed_point_alu.sv -----
// Path: cmd transfer to rsp valid passes the entry register, the divider stages (two quotient
//   bits per stage), the rounding register and the output register.
// Throughput: one transfer per cycle; all operations share the one pipeline, which halts
//   only while a finished result waits on rsp.ready.
// Reset: arst_n clears the stage valid bits and loads int_bits 16, frac_bits 16, round
//   nearest even.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int GUARD_BITS = GUARD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	fpa_cmd_if.sink              cmd,
	fpa_rsp_if.source            rsp
);

	localparam int MW   = MAX_WIDTH;
	localparam int BPS  = 2;
	localparam int DW   = MW + FRAC_MAX + GUARD_BITS;
	localparam int NDIV = (DW + BPS - 1) / BPS;
	localparam int DPW  = NDIV * BPS;
	localparam int QW   = MW + GUARD_BITS;
	localparam int PW   = 2 * MW;
	localparam int VW   = (PW > QW) ? PW : QW;
	localparam int WW   = INT_W + 1;

	typedef struct packed {
		op_t             op;
		logic            neg;
		logic            dz;
		rmode_t          rm;
		logic [FRAC_W-1:0] fr;
		logic [MW-1:0]   mask;
		logic [MW-1:0]   addsub;
		logic [MW-1:0]   dvs;
		logic [MW-1:0]   rem;
		logic [DPW-1:0]  dvd;
		logic [QW-1:0]   quo;
		logic [PW-1:0]   prod;
	} pipe_t;

	logic [INT_W-1:0]  int_bits_q;
	logic [FRAC_W-1:0] frac_bits_q;
	rmode_t            rmode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_bits_q  <= INT_BITS_RST;
			frac_bits_q <= FRAC_BITS_RST;
			rmode_q     <= RMODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INT_BITS:   int_bits_q  <= cfg_data[INT_W-1:0];
				CFG_FRAC_BITS:  frac_bits_q <= cfg_data[FRAC_W-1:0];
				CFG_ROUND_MODE: rmode_q     <= rmode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_vld_q;
	assign adv       = !out_vld_q || rsp.ready;
	assign cmd.ready = adv;

	// entry: width, mask, magnitudes, add/sub
	pipe_t ent;
	always_comb begin
		logic [WW-1:0]   w;
		logic [MW:0]     m_wide;
		logic [MW-1:0]   mask, top, a, b, am, bm;
		logic            na, nb;
		w = WW'(int_bits_q) + WW'(frac_bits_q);
		if (w > WW'(MW))
			w = WW'(MW);
		if (w == '0)
			w = WW'(1);
		m_wide = ({{MW{1'b0}}, 1'b1} << w) - 1'b1;
		mask = m_wide[MW-1:0];
		top  = mask ^ (mask >> 1);
		a  = cmd.operand_a[MW-1:0] & mask;
		b  = cmd.operand_b[MW-1:0] & mask;
		na = |(a & top);
		nb = |(b & top);
		am = na ? ((~a + 1'b1) & mask) : a;
		bm = nb ? ((~b + 1'b1) & mask) : b;
		ent        = '0;
		ent.op     = op_t'(cmd.operation);
		ent.neg    = na ^ nb;
		ent.rm     = rmode_q;
		ent.fr     = frac_bits_q;
		ent.mask   = mask;
		ent.dvs    = bm;
		ent.dz     = (ent.op == OP_DIV) && (bm == '0);
		ent.addsub = ((ent.op == OP_SUB) ? (a - b) : (a + b)) & mask;
		ent.dvd    = DPW'(am) << (FRAC_W'(frac_bits_q) + GUARD_BITS);
		ent.prod   = PW'(am);
	end

	pipe_t p_s [0:NDIV];
	logic  v_s [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (adv)
			v_s[0] <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			p_s[0] <= ent;
	end

	for (genvar i = 1; i <= NDIV; i++) begin : g_div
		logic [MW-1:0]  rem_n;
		logic [BPS-1:0] quo_n;
		pipe_t          nx;

		fpa_div_step #(.MW(MW), .BPS(BPS)) u_step (
			.rem_i (p_s[i-1].rem),
			.dvd_i (p_s[i-1].dvd[DPW-1 -: BPS]),
			.dvs   (p_s[i-1].dvs),
			.rem_o (rem_n),
			.quo_o (quo_n)
		);

		always_comb begin
			nx     = p_s[i-1];
			nx.rem = rem_n;
			nx.dvd = p_s[i-1].dvd << BPS;
			nx.quo = QW'({p_s[i-1].quo, quo_n});
			if (i == 1)
				nx.prod = {{MW{1'b0}}, p_s[0].prod[MW-1:0]} * {{MW{1'b0}}, p_s[0].dvs};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (adv)
				v_s[i] <= v_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (adv)
				p_s[i] <= nx;
		end
	end

	// rounding of the product or of the guard bits
	pipe_t         pl;
	logic [MW-1:0] mag_n;
	assign pl = p_s[NDIV];

	always_comb begin
		logic [VW-1:0] v, down, lm, hm;
		logic [5:0]    k;
		logic          rnz, g, sticky, inc;
		if (pl.op == OP_MUL) begin
			v = VW'(pl.prod);
			k = 6'(pl.fr);
		end else begin
			v = VW'(pl.quo);
			k = 6'(GUARD_BITS);
		end
		down   = v >> k;
		lm     = ~({VW{1'b1}} << k);
		hm     = ~({VW{1'b1}} << (k - 6'd1));
		rnz    = |(v & lm);
		g      = (k != '0) && ((v >> (k - 6'd1)) & VW'(1)) != '0;
		sticky = (k != '0) && |(v & hm);
		unique case (pl.rm)
			RM_ZERO:    inc = 1'b0;
			RM_NEAREST: inc = g && (sticky || down[0]);
			RM_POS:     inc = rnz && !pl.neg;
			RM_NEG:     inc = rnz && pl.neg;
			default:    inc = 1'b0;
		endcase
		mag_n = down[MW-1:0] + MW'(inc);
	end

	logic          v_sr;
	op_t           op_sr;
	logic          neg_sr, dz_sr;
	logic [MW-1:0] mask_sr, addsub_sr, mag_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sr <= 1'b0;
		else if (adv)
			v_sr <= v_s[NDIV];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_sr     <= pl.op;
			neg_sr    <= pl.neg;
			dz_sr     <= pl.dz;
			mask_sr   <= pl.mask;
			addsub_sr <= pl.addsub;
			mag_sr    <= mag_n;
		end
	end

	logic [MW-1:0] res_n;
	always_comb begin
		logic [MW-1:0] m;
		m = mag_sr & mask_sr;
		unique case (op_sr)
			OP_ADD, OP_SUB: res_n = addsub_sr;
			OP_MUL, OP_DIV: begin
				if (dz_sr)
					res_n = '0;
				else if (neg_sr)
					res_n = (~m + 1'b1) & mask_sr;
				else
					res_n = m;
			end
			default: res_n = '0;
		endcase
	end

	logic [DATA_W-1:0] res_q;
	logic              dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= v_sr;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= DATA_W'(res_n);
			dz_q  <= dz_sr;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.result_value = res_q;
	assign rsp.div_by_zero  = dz_q;

endmodule

// ----- sv/fpa_div_step.sv -----
module fpa_div_step import fpa_pkg::*; #(
	parameter int MW  = MAX_WIDTH_DEF,
	parameter int BPS = 2
) (
	input  logic [MW-1:0]  rem_i,
	input  logic [BPS-1:0] dvd_i,
	input  logic [MW-1:0]  dvs,
	output logic [MW-1:0]  rem_o,
	output logic [BPS-1:0] quo_o
);

	// restoring division, BPS quotient bits, msb first
	always_comb begin
		logic [MW:0]   trial;
		logic [MW-1:0] r;
		r = rem_i;
		quo_o = '0;
		for (int i = BPS - 1; i >= 0; i--) begin
			trial = {r, dvd_i[i]};
			if (trial >= {1'b0, dvs}) begin
				trial = trial - {1'b0, dvs};
				quo_o[i] = 1'b1;
			end
			r = trial[MW-1:0];
		end
		rem_o = r;
	end

endmodule

// ----- sv/fpa_checker.sv -----
module fpa_checker import fpa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] result_value,
	input logic              div_by_zero
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped before transfer");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(result_value) && $stable(div_by_zero))
		else $error("rsp payload changed while stalled");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_by_zero |-> result_value == '0)
		else $error("divide by zero with nonzero result");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid || rsp_ready |-> cmd_ready)
		else $error("cmd stalled with free output");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.result_value (rsp.result_value),
	.div_by_zero  (rsp.div_by_zero)
);
